[rtl/sb2da_pkg.sv]
// Shared constants and controller/datapath handshake types for the
// signed binary to decimal ASCII converter. No dependencies.
package sb2da_pkg;

    // Input word and decimal sizing
    localparam int VALUE_BITS = 32;
    localparam int BCD_DIGITS = 10;               // digits of 2^31
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(BCD_DIGITS + 1);
    localparam int CHAR_W     = 8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture magnitude and sign, clear BCD
        logic conv_step;   // one shift-add-3 step
        logic skip_step;   // drop a leading zero digit
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // load top digit into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic conv_done;   // current step is the last shift
        logic top_zero;    // most significant BCD digit is zero
        logic cnt_one;     // one digit left
        logic negative;    // input was negative
        logic out_free;    // output register can take a character
    } dp_status_t;

endpackage

[rtl/sb2da_datapath.sv]
// Datapath: magnitude and BCD registers for double dabble conversion,
// digit counter and the output character register. Uses sb2da_pkg.
module sb2da_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [sb2da_pkg::VALUE_BITS-1:0] value,
    input  sb2da_pkg::dp_cmd_t                  cmd,
    output sb2da_pkg::dp_status_t               status,
    output logic [sb2da_pkg::CHAR_W-1:0]        character,
    output logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready
);

    logic [sb2da_pkg::VALUE_BITS-1:0] bin_reg;
    logic [sb2da_pkg::BCD_W-1:0]      bcd_reg;
    logic [sb2da_pkg::BCD_W-1:0]      bcd_adj;
    logic [sb2da_pkg::VALUE_BITS-1:0] mag;
    logic                             neg_reg;
    logic [sb2da_pkg::STEP_W-1:0]     step_reg;
    logic [sb2da_pkg::CNT_W-1:0]      cnt_reg;
    logic [sb2da_pkg::CHAR_W-1:0]     char_reg;
    logic                             last_reg;
    logic                             out_valid_reg;
    logic [3:0]                       top_digit;

    // Unsigned magnitude; the most negative value maps onto itself correctly
    assign mag = value[sb2da_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;

    // Add 3 to every BCD digit of 5 or more ahead of the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < sb2da_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    assign top_digit = bcd_reg[sb2da_pkg::BCD_W-1 -: 4];

    // Status back to the controller
    assign status.conv_done = (step_reg == sb2da_pkg::STEP_W'(sb2da_pkg::VALUE_BITS - 1));
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.cnt_one   = (cnt_reg == sb2da_pkg::CNT_W'(1));
    assign status.negative  = neg_reg;
    assign status.out_free  = ~out_valid_reg | out_ready;

    // Control registers: step and digit counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
                cnt_reg  <= sb2da_pkg::CNT_W'(sb2da_pkg::BCD_DIGITS);
            end
            else if (cmd.conv_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else if (cmd.skip_step || cmd.emit_digit)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= mag;
            bcd_reg <= '0;
            neg_reg <= value[sb2da_pkg::VALUE_BITS-1];
        end
        else if (cmd.conv_step)
        begin
            bcd_reg <= {bcd_adj[sb2da_pkg::BCD_W-2:0], bin_reg[sb2da_pkg::VALUE_BITS-1]};
            bin_reg <= {bin_reg[sb2da_pkg::VALUE_BITS-2:0], 1'b0};
        end
        else if (cmd.skip_step || cmd.emit_digit)
        begin
            bcd_reg <= {bcd_reg[sb2da_pkg::BCD_W-5:0], 4'd0};
        end

        if (cmd.emit_sign)
        begin
            char_reg <= sb2da_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sb2da_pkg::CHAR_ZERO + {4'd0, top_digit};
            last_reg <= status.cnt_one;
        end
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

endmodule

[rtl/sb2da_ctrl.sv]
// Controller state machine: sequences load, conversion, leading zero
// skip and character emission. Uses sb2da_pkg.
module sb2da_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sb2da_pkg::dp_status_t status,
    output sb2da_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (status.top_zero && !status.cnt_one)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = status.negative ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/signed_binary_to_decimal_ascii.sv]
// Top level of the signed binary to decimal ASCII converter.
// Joins sb2da_ctrl and sb2da_datapath; uses sb2da_pkg.
//
//   channel  signals                      width  transfer
//   in       in_valid/in_ready, value     32     one signed integer
//   out      out_valid/out_ready,         8 + 1  one character, last set
//            character, last                     on the final one of a text
//
// An item takes a load, 32 double dabble shift steps, a pass that drops leading
// zero digits, then one character per cycle (up to 11) when the output is not
// stalled. The 32-step shift-add-3 loop and the one-character output register
// set the throughput.
// A new value is taken once the last character is in the output register.
// Reset clears the state machine, counters and output valid.
module signed_binary_to_decimal_ascii
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [sb2da_pkg::VALUE_BITS-1:0] value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sb2da_pkg::CHAR_W-1:0]          character,
    output logic                                  last
);

    sb2da_pkg::dp_cmd_t    cmd;
    sb2da_pkg::dp_status_t status;

    sb2da_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sb2da_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

[dv/signed_binary_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for signed_binary_to_decimal_ascii: directed and random
// signed values in, decimal text checked character by character. Uses sb2da_pkg.
module signed_binary_to_decimal_ascii_tb;

    localparam int VALUE_BITS = sb2da_pkg::VALUE_BITS;
    localparam int CHAR_W     = sb2da_pkg::CHAR_W;
    localparam int BCD_DIGITS = sb2da_pkg::BCD_DIGITS;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = sb2da_pkg::CHAR_ZERO;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = sb2da_pkg::CHAR_MINUS;

    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_LIMIT  = 20000;   // cycles allowed for the last texts
    localparam int SETTLE_WAIT  = 60;      // settle wait after drain to catch stray characters
    localparam int TIMEOUT_NS   = 5000000;

    // One expected character of a decimal text
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } text_char_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_e;
    typedef enum int {GEN_DIGITS, GEN_FULL, GEN_SMALL, GEN_POW10, GEN_EDGES} gen_mode_e;

    // Expected text store and decimal predictor
    class decimal_text_scoreboard;
        text_char_t text_q[$];
        int         mismatches;
        int         values_seen;
        int         negatives_seen;
        int         chars_checked;

        function new();
            mismatches     = 0;
            values_seen    = 0;
            negatives_seen = 0;
            chars_checked  = 0;
        endfunction

        // Append the decimal text of an accepted value
        function void note_value(input logic [VALUE_BITS-1:0] v);
            logic [VALUE_BITS-1:0] mag;
            logic [CHAR_W-1:0]     digits [BCD_DIGITS];
            logic                  neg;
            int                    ndig;
            text_char_t            tc;
            neg  = v[VALUE_BITS-1];
            // unsigned magnitude, so the most negative value is fine
            mag  = neg ? (~v + 1'b1) : v;
            ndig = 0;
            do
            begin
                digits[ndig] = CHAR_ZERO + CHAR_W'(mag % 10);
                ndig++;
                mag = mag / 10;
            end
            while (mag != 0);
            if (neg)
            begin
                tc.code    = CHAR_MINUS;
                tc.is_last = 1'b0;
                text_q.push_back(tc);
                negatives_seen++;
            end
            for (int k = ndig - 1; k >= 0; k--)
            begin
                tc.code    = digits[k];
                tc.is_last = (k == 0);
                text_q.push_back(tc);
            end
            values_seen++;
        endfunction

        // Compare one output transfer against the oldest expected character
        function void check_char(input logic [CHAR_W-1:0] code, input logic is_last);
            text_char_t exp;
            if (text_q.size() == 0)
            begin
                $error("unexpected character: got %0d, last %0b", code, is_last);
                mismatches++;
                return;
            end
            exp = text_q.pop_front();
            chars_checked++;
            if (exp.code !== code)
            begin
                $error("character: expected %0d, actual %0d", exp.code, code);
                mismatches++;
            end
            if (exp.is_last !== is_last)
            begin
                $error("last: expected %0b, actual %0b", exp.is_last, is_last);
                mismatches++;
            end
        endfunction

        function int pending();
            return text_q.size();
        endfunction
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic signed [VALUE_BITS-1:0] value     = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [CHAR_W-1:0]            character;
    logic                         last;

    decimal_text_scoreboard sb = new();

    int       burst_left = 0;
    rx_mode_e rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       rx_stall   = 0;

    signed_binary_to_decimal_ascii u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-time limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // Random value with an interesting decimal shape
    function automatic logic [VALUE_BITS-1:0] random_value();
        gen_mode_e   mode;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mag;
        int          n;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      mode = GEN_DIGITS;
        else if (pick < 65) mode = GEN_FULL;
        else if (pick < 80) mode = GEN_SMALL;
        else if (pick < 90) mode = GEN_POW10;
        else                mode = GEN_EDGES;
        case (mode)
            GEN_DIGITS:
            begin
                // uniform over digit count, then uniform within that count
                n  = $urandom_range(1, 10);
                lo = 64'd1;
                for (int i = 1; i < n; i++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (n == 1) lo = 64'd0;
                if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
                mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
            end
            GEN_FULL:
                return $urandom;
            GEN_SMALL:
                mag = 64'($urandom_range(0, 20));
            GEN_POW10:
            begin
                mag = 64'd1;
                n   = $urandom_range(0, 9);
                for (int i = 0; i < n; i++) mag = mag * 10;
                mag = mag + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default:
            begin
                // near the ends of the range
                mag = 64'h8000_0000 - 64'($urandom_range(0, 3));
                if (!$urandom_range(0, 1)) return VALUE_BITS'(mag);
            end
        endcase
        if ($urandom_range(0, 1)) return ~VALUE_BITS'(mag) + 1'b1;
        return VALUE_BITS'(mag);
    endfunction

    // Hold valid until the transfer happens; called right after a rising edge
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_value(v);
    endtask

    // Bursts of back-to-back transfers separated by random gaps
    task automatic send_paced(input logic [VALUE_BITS-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        send_value(v);
    endtask

    // Pause the sender until every expected character has come out
    task automatic drain_texts();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Receiver: check each transfer, then pick the next ready value
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_char(character, last);
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:
                    out_ready <= 1'b1;
                RX_COIN:
                    out_ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (rx_stall > 0)
                    begin
                        rx_stall--;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 15);
                    end
                end
            endcase
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [VALUE_BITS-1:0] directed [$];
        int                    waited;
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                     32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'd999999999, 32'd1000000000, -32'sd1000000000,
                     -32'sd999999999, 32'd12345, -32'sd54321, 32'h5555_5555,
                     32'hAAAA_AAAA, -32'sd9, 32'd4294967286};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed values: extremes, zero, digit-count boundaries
        foreach (directed[i]) send_paced(directed[i]);
        drain_texts();

        // random values, with one full drain midway
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2) drain_texts();
            send_paced(random_value());
        end
        in_valid <= 1'b0;

        // wait for the remaining texts, then a settle wait for strays
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
        begin
            $error("%0d expected characters never arrived", sb.pending());
            sb.mismatches++;
        end
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("Converted %0d values (%0d negative), checked %0d characters.",
                 sb.values_seen, sb.negatives_seen, sb.chars_checked);
        $display("Covered zero, both range ends, digit-count boundaries and random stalls.");
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/sb2da_pkg.sv
rtl/sb2da_datapath.sv
rtl/sb2da_ctrl.sv
rtl/signed_binary_to_decimal_ascii.sv
dv/signed_binary_to_decimal_ascii_tb.sv
